FILE: src/grid_astar_search_step_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid A* search step block
// Helpers that wrap clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_SEARCH_STEP_DEFINES_SVH
`define GRID_ASTAR_SEARCH_STEP_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define GASS_ASSERT(name, prop, msg) name: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define GASS_NEVER(name, cond, msg) name: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/gass_pkg.sv
// ----------------------------------------------------------------------------
// Grid A* search step package
// Types, constants and small helper functions shared by all block files.
// ----------------------------------------------------------------------------
package gass_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int OPEN_DEPTH = 4096;

  localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int OPEN_AW = $clog2(OPEN_DEPTH);
  localparam int CNT_W   = $clog2(OPEN_DEPTH + 1);

  localparam int COORD_W    = 6;
  localparam int DIM_W      = 7;
  localparam int G_W        = 17;
  localparam int F_W        = 18;
  localparam int D2_W       = 13;
  localparam int SQ_IN_W    = 33;
  localparam int ROOT_W     = 17;
  localparam int SQ_STEPS   = (SQ_IN_W + 1) / 2;
  localparam int STATUS_W   = 3;
  localparam int SIZE_W     = 13;
  localparam int OP_W       = 2;
  localparam int K_W        = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [G_W-1:0]  G_MAX         = 17'h1FFFF;
  localparam logic [G_W-1:0]  COST_STRAIGHT = 17'd10;
  localparam logic [G_W-1:0]  COST_DIAGONAL = 17'd14;
  localparam logic [19:0]     H_SCALE       = 20'd1000000;
  localparam logic [K_W-1:0]  NB_LAST       = 3'd7;

  localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 7'd64;
  localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 7'd48;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_CELL = 2'd0,
    OP_EXPAND     = 2'd1,
    OP_RESTART    = 2'd2,
    OP_UNUSED     = 2'd3
  } item_op_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_DONE     = 3'd0,
    RES_EXPANDED = 3'd1,
    RES_GOAL     = 3'd2,
    RES_EMPTY    = 3'd3,
    RES_FINISHED = 3'd4
  } result_e;

  typedef enum logic [1:0] {
    CELL_FREE   = 2'd0,
    CELL_OBST   = 2'd1,
    CELL_CLOSED = 2'd2,
    CELL_OPEN   = 2'd3
  } cell_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_GOAL_X      = 3'd4,
    CFG_GOAL_Y      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               blocked;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  node_x;
    logic [COORD_W-1:0]  node_y;
    logic [G_W-1:0]      node_cost;
    logic [SIZE_W-1:0]   open_size;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [G_W-1:0]     g;
    logic [ROOT_W-1:0]  h;
  } open_entry_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_CLEAR,
    DP_ACCEPT,
    DP_DISPATCH,
    DP_WR_RD,
    DP_WR_WB,
    DP_RS_RD,
    DP_RS_WR,
    DP_SEED,
    DP_SCAN,
    DP_GOAL,
    DP_SHIFT,
    DP_CLOSE,
    DP_NB_CHK,
    DP_NB_CELL,
    DP_RELAX,
    DP_H_SQ,
    DP_H_MUL,
    DP_H_START,
    DP_H_WAIT,
    DP_INSERT,
    DP_NB_NEXT,
    DP_RESP
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WR_RD,
    S_WR_WB,
    S_RS_RD,
    S_RS_WR,
    S_SEED,
    S_SCAN,
    S_GOAL,
    S_SHIFT,
    S_CLOSE,
    S_NB_CHK,
    S_NB_CELL,
    S_RELAX,
    S_H_SQ,
    S_H_MUL,
    S_H_START,
    S_H_WAIT,
    S_INSERT,
    S_NB_NEXT,
    S_RESP
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    result_e code;
  } cmd_t;

  typedef struct packed {
    logic     clr_last;
    item_op_e item_op;
    logic     done;
    logic     cnt_zero;
    logic     cnt_full;
    logic     scan_end;
    logic     cur_goal;
    logic     nb_out;
    cell_e    nb_cell;
    logic     k_last;
    logic     sq_done;
    logic     out_free;
  } status_t;

  // Neighbour order: E, W, S, N, NW, NE, SE, SW.
  function automatic logic signed [1:0] nb_dx(input logic [K_W-1:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd0, 3'd5, 3'd6: d = 2'sd1;
      3'd1, 3'd4, 3'd7: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [K_W-1:0] k);
    logic signed [1:0] d;
    unique case (k)
      3'd2, 3'd6, 3'd7: d = 2'sd1;
      3'd3, 3'd4, 3'd5: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic [G_W-1:0] nb_cost(input logic [K_W-1:0] k);
    return k[2] ? COST_DIAGONAL : COST_STRAIGHT;
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    return CELL_AW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  function automatic logic in_store(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y);
    return (int'(x) < MAX_WIDTH) && (int'(y) < MAX_HEIGHT);
  endfunction

endpackage

FILE: src/gass_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root unit
// Bit-pair restoring square root, one result bit per clock cycle.
// ----------------------------------------------------------------------------
module gass_isqrt import gass_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SQ_IN_W-1:0] operand_i,
  output logic               done_o,
  output logic [ROOT_W-1:0]  root_o
);

  localparam int ACC_W  = SQ_IN_W + 1;
  localparam int STEP_W = $clog2(SQ_STEPS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SQ_IN_W-1:0] rem_q, rem_d;
  logic [ACC_W-1:0]  res_q, res_d;
  logic [ACC_W-1:0]  bit_q, bit_d;
  logic [ACC_W-1:0]  sum;

  assign sum = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = operand_i;
      res_d  = '0;
      bit_d  = ACC_W'(1) << (2 * (SQ_STEPS - 1));
    end else if (busy_q) begin
      if (ACC_W'(rem_q) >= sum) begin
        rem_d = SQ_IN_W'(ACC_W'(rem_q) - sum);
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d  = bit_q >> 2;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SQ_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

FILE: src/gass_ctrl.sv
// ----------------------------------------------------------------------------
// Grid A* search step controller
// Sequences the datapath through the clearing pass and the write, restart and expansion phases.
// ----------------------------------------------------------------------------
module gass_ctrl import gass_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  result_e     code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      code_q  <= RES_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    cmd_o.op    = DP_NONE;
    cmd_o.code  = code_q;
    in_stall_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_ACCEPT;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.op = DP_DISPATCH;
        unique case (status_i.item_op)
          OP_WRITE_CELL: state_d = S_WR_RD;
          OP_RESTART:    state_d = S_RS_RD;
          OP_EXPAND: begin
            priority if (status_i.done) begin
              code_d  = RES_FINISHED;
              state_d = S_RESP;
            end else if (status_i.cnt_zero) begin
              code_d  = RES_EMPTY;
              state_d = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_UNUSED: begin
            code_d  = RES_DONE;
            state_d = S_RESP;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WR_RD: begin
        cmd_o.op = DP_WR_RD;
        state_d  = S_WR_WB;
      end
      S_WR_WB: begin
        cmd_o.op = DP_WR_WB;
        code_d   = RES_DONE;
        state_d  = S_RESP;
      end
      S_RS_RD: begin
        cmd_o.op = DP_RS_RD;
        state_d  = S_RS_WR;
      end
      S_RS_WR: begin
        cmd_o.op = DP_RS_WR;
        state_d  = status_i.clr_last ? S_SEED : S_RS_RD;
      end
      S_SEED: begin
        cmd_o.op = DP_SEED;
        code_d   = RES_DONE;
        state_d  = S_RESP;
      end
      S_SCAN: begin
        cmd_o.op = DP_SCAN;
        if (status_i.scan_end) state_d = S_GOAL;
      end
      S_GOAL: begin
        cmd_o.op = DP_GOAL;
        if (status_i.cur_goal) begin
          code_d  = RES_GOAL;
          state_d = S_RESP;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.op = DP_SHIFT;
        if (status_i.scan_end) state_d = S_CLOSE;
      end
      S_CLOSE: begin
        cmd_o.op = DP_CLOSE;
        state_d  = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd_o.op = DP_NB_CHK;
        state_d  = status_i.nb_out ? S_NB_NEXT : S_NB_CELL;
      end
      S_NB_CELL: begin
        cmd_o.op = DP_NB_CELL;
        unique case (status_i.nb_cell)
          CELL_OPEN: state_d = S_RELAX;
          CELL_FREE: state_d = status_i.cnt_full ? S_NB_NEXT : S_H_SQ;
          default:   state_d = S_NB_NEXT;
        endcase
      end
      S_RELAX: begin
        cmd_o.op = DP_RELAX;
        if (status_i.scan_end) state_d = S_NB_NEXT;
      end
      S_H_SQ: begin
        cmd_o.op = DP_H_SQ;
        state_d  = S_H_MUL;
      end
      S_H_MUL: begin
        cmd_o.op = DP_H_MUL;
        state_d  = S_H_START;
      end
      S_H_START: begin
        cmd_o.op = DP_H_START;
        state_d  = S_H_WAIT;
      end
      S_H_WAIT: begin
        cmd_o.op = DP_H_WAIT;
        if (status_i.sq_done) state_d = S_INSERT;
      end
      S_INSERT: begin
        cmd_o.op = DP_INSERT;
        state_d  = S_NB_NEXT;
      end
      S_NB_NEXT: begin
        cmd_o.op = DP_NB_NEXT;
        if (status_i.k_last) begin
          code_d  = RES_EXPANDED;
          state_d = S_RESP;
        end else begin
          state_d = S_NB_CHK;
        end
      end
      S_RESP: begin
        cmd_o.op = DP_RESP;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: src/gass_dp.sv
// ----------------------------------------------------------------------------
// Grid A* search step datapath
// Cell map and open list memories, scan pipeline, heuristic and result register.
// ----------------------------------------------------------------------------
`include "grid_astar_search_step_defines.svh"

module gass_dp import gass_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  in_item_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output out_item_t             out_data_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);

  // Configuration registers.
  logic [DIM_W-1:0]   gw_q, gh_q;
  logic [COORD_W-1:0] sx_q, sy_q, gx_q, gy_q;

  // Search state.
  in_item_t           item_q, item_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [CELL_AW-1:0] sweep_q, sweep_d;
  logic [CNT_W-1:0]   scan_idx_q, scan_idx_d;
  logic               pipe_v_q, pipe_v_d;
  logic [OPEN_AW-1:0] pipe_idx_q, pipe_idx_d;
  logic [OPEN_AW-1:0] best_idx_q, best_idx_d;
  logic [F_W-1:0]     best_f_q, best_f_d;
  open_entry_t        cur_q, cur_d;
  logic               found_q, found_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [COORD_W-1:0] nx_q, nx_d, ny_q, ny_d;
  logic [CELL_AW-1:0] ncell_q, ncell_d;
  logic [G_W-1:0]     ng_q, ng_d;
  logic [D2_W-1:0]    d2_q, d2_d;
  logic [SQ_IN_W-1:0] sqv_q, sqv_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // Memories.
  cell_e              cell_mem [CELLS];
  cell_e              cell_rd_q;
  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  cell_e              cell_wdata;
  open_entry_t        open_mem [OPEN_DEPTH];
  open_entry_t        open_rd_q;
  logic               open_we;
  logic [OPEN_AW-1:0] open_waddr, open_raddr;
  open_entry_t        open_wdata;

  // Combinational helpers.
  open_entry_t        seed;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic signed [1:0]  dxk, dyk;
  logic signed [7:0]  nx_s, ny_s;
  logic               nb_out;
  logic [CELL_AW-1:0] nb_addr;
  logic [F_W-1:0]     ng_sum, rd_f;
  logic [G_W-1:0]     ng_sat;
  logic               scan_issue, out_free, cur_goal;
  logic [COORD_W-1:0] hdx, hdy;
  logic [11:0]        hdx2, hdy2;
  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  sq_root;

  gass_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sqv_q),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  assign seed = '{x: sx_q, y: sy_q, g: '0, h: '0};

  assign w_eff = (gw_q == '0) ? DIM_W'(1) :
                 ((gw_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : gw_q);
  assign h_eff = (gh_q == '0) ? DIM_W'(1) :
                 ((gh_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : gh_q);

  assign dxk  = nb_dx(k_q);
  assign dyk  = nb_dy(k_q);
  assign nx_s = $signed({2'b00, cur_q.x}) + $signed({{6{dxk[1]}}, dxk});
  assign ny_s = $signed({2'b00, cur_q.y}) + $signed({{6{dyk[1]}}, dyk});
  assign nb_out = nx_s[7] || ny_s[7] ||
                  (nx_s[DIM_W-1:0] >= w_eff) || (ny_s[DIM_W-1:0] >= h_eff);
  assign nb_addr = cell_addr(nx_s[COORD_W-1:0], ny_s[COORD_W-1:0]);

  assign ng_sum = {1'b0, cur_q.g} + {1'b0, nb_cost(k_q)};
  assign ng_sat = (ng_sum > {1'b0, G_MAX}) ? G_MAX : ng_sum[G_W-1:0];
  assign rd_f   = {1'b0, open_rd_q.g} + {1'b0, open_rd_q.h};

  assign scan_issue = (scan_idx_q < cnt_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_goal   = (cur_q.x == gx_q) && (cur_q.y == gy_q);

  assign hdx  = (nx_q > gx_q) ? (nx_q - gx_q) : (gx_q - nx_q);
  assign hdy  = (ny_q > gy_q) ? (ny_q - gy_q) : (gy_q - ny_q);
  assign hdx2 = hdx * hdx;
  assign hdy2 = hdy * hdy;

  always_comb begin
    item_d      = item_q;
    cnt_d       = cnt_q;
    done_d      = done_q;
    sweep_d     = sweep_q;
    scan_idx_d  = scan_idx_q;
    pipe_v_d    = 1'b0;
    pipe_idx_d  = scan_idx_q[OPEN_AW-1:0];
    best_idx_d  = best_idx_q;
    best_f_d    = best_f_q;
    cur_d       = cur_q;
    found_d     = found_q;
    k_d         = k_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    ncell_d     = ncell_q;
    ng_d        = ng_q;
    d2_d        = d2_q;
    sqv_d       = sqv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cell_we     = 1'b0;
    cell_waddr  = sweep_q;
    cell_wdata  = CELL_FREE;
    cell_raddr  = sweep_q;
    open_we     = 1'b0;
    open_waddr  = '0;
    open_wdata  = seed;
    open_raddr  = scan_idx_q[OPEN_AW-1:0];
    sq_start    = 1'b0;

    unique case (cmd_i.op)
      DP_CLEAR: begin
        // The clearing pass also writes the start entry into open-list slot 0.
        cell_we = 1'b1;
        open_we = 1'b1;
        sweep_d = sweep_q + CELL_AW'(1);
      end
      DP_ACCEPT: item_d = in_data_i;
      DP_DISPATCH: begin
        sweep_d    = '0;
        scan_idx_d = '0;
      end
      DP_WR_RD: cell_raddr = cell_addr(item_q.cell_x, item_q.cell_y);
      DP_WR_WB: begin
        if (in_store(item_q.cell_x, item_q.cell_y) &&
            (cell_rd_q == CELL_FREE || cell_rd_q == CELL_OBST)) begin
          cell_we    = 1'b1;
          cell_waddr = cell_addr(item_q.cell_x, item_q.cell_y);
          cell_wdata = item_q.blocked ? CELL_OBST : CELL_FREE;
        end
      end
      DP_RS_RD: cell_raddr = sweep_q;
      DP_RS_WR: begin
        if (cell_rd_q == CELL_CLOSED || cell_rd_q == CELL_OPEN) cell_we = 1'b1;
        sweep_d = sweep_q + CELL_AW'(1);
      end
      DP_SEED: begin
        open_we = 1'b1;
        cnt_d   = CNT_W'(1);
        done_d  = 1'b0;
      end
      DP_SCAN: begin
        if (scan_issue) begin
          scan_idx_d = scan_idx_q + CNT_W'(1);
          pipe_v_d   = 1'b1;
        end
        // Strict compare keeps the earliest entry on ties.
        if (pipe_v_q && (pipe_idx_q == '0 || rd_f < best_f_q)) begin
          best_idx_d = pipe_idx_q;
          best_f_d   = rd_f;
          cur_d      = open_rd_q;
        end
      end
      DP_GOAL: begin
        if (cur_goal) done_d = 1'b1;
        scan_idx_d = CNT_W'(best_idx_q) + CNT_W'(1);
      end
      DP_SHIFT: begin
        if (scan_issue) begin
          scan_idx_d = scan_idx_q + CNT_W'(1);
          pipe_v_d   = 1'b1;
        end
        if (pipe_v_q) begin
          open_we    = 1'b1;
          open_waddr = pipe_idx_q - OPEN_AW'(1);
          open_wdata = open_rd_q;
        end
      end
      DP_CLOSE: begin
        cnt_d = cnt_q - CNT_W'(1);
        k_d   = '0;
        if (in_store(cur_q.x, cur_q.y)) begin
          cell_we    = 1'b1;
          cell_waddr = cell_addr(cur_q.x, cur_q.y);
          cell_wdata = CELL_CLOSED;
        end
      end
      DP_NB_CHK: begin
        cell_raddr = nb_addr;
        nx_d       = nx_s[COORD_W-1:0];
        ny_d       = ny_s[COORD_W-1:0];
        ncell_d    = nb_addr;
        ng_d       = ng_sat;
      end
      DP_NB_CELL: begin
        scan_idx_d = '0;
        found_d    = 1'b0;
      end
      DP_RELAX: begin
        if (scan_issue) begin
          scan_idx_d = scan_idx_q + CNT_W'(1);
          pipe_v_d   = 1'b1;
        end
        if (pipe_v_q && !found_q && open_rd_q.x == nx_q && open_rd_q.y == ny_q) begin
          found_d = 1'b1;
          if (ng_q < open_rd_q.g) begin
            open_we    = 1'b1;
            open_waddr = pipe_idx_q;
            open_wdata = '{x: open_rd_q.x, y: open_rd_q.y, g: ng_q, h: open_rd_q.h};
          end
        end
      end
      DP_H_SQ:    d2_d = D2_W'(hdx2) + D2_W'(hdy2);
      DP_H_MUL:   sqv_d = SQ_IN_W'(d2_q) * SQ_IN_W'(H_SCALE);
      DP_H_START: sq_start = 1'b1;
      DP_INSERT: begin
        open_we    = 1'b1;
        open_waddr = cnt_q[OPEN_AW-1:0];
        open_wdata = '{x: nx_q, y: ny_q, g: ng_q, h: sq_root};
        cnt_d      = cnt_q + CNT_W'(1);
        cell_we    = 1'b1;
        cell_waddr = ncell_q;
        cell_wdata = CELL_OPEN;
      end
      DP_NB_NEXT: k_d = k_q + K_W'(1);
      DP_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.status    = cmd_i.code;
          out_d.open_size = SIZE_W'(cnt_q);
          if (cmd_i.code == RES_EXPANDED || cmd_i.code == RES_GOAL) begin
            out_d.node_x    = cur_q.x;
            out_d.node_y    = cur_q.y;
            out_d.node_cost = cur_q.g;
          end else begin
            out_d.node_x    = '0;
            out_d.node_y    = '0;
            out_d.node_cost = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GRID_WIDTH_RST;
      gh_q <= GRID_HEIGHT_RST;
      sx_q <= '0;
      sy_q <= '0;
      gx_q <= '0;
      gy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH:  gw_q <= cfg_wdata_i;
        CFG_GRID_HEIGHT: gh_q <= cfg_wdata_i;
        CFG_START_X:     sx_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_START_Y:     sy_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_GOAL_X:      gx_q <= cfg_wdata_i[COORD_W-1:0];
        CFG_GOAL_Y:      gy_q <= cfg_wdata_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      done_q      <= 1'b0;
      sweep_q     <= '0;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      sweep_q     <= sweep_d;
      pipe_v_q    <= pipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    scan_idx_q <= scan_idx_d;
    pipe_idx_q <= pipe_idx_d;
    best_idx_q <= best_idx_d;
    best_f_q   <= best_f_d;
    cur_q      <= cur_d;
    found_q    <= found_d;
    k_q        <= k_d;
    nx_q       <= nx_d;
    ny_q       <= ny_d;
    ncell_q    <= ncell_d;
    ng_q       <= ng_d;
    d2_q       <= d2_d;
    sqv_q      <= sqv_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    cell_rd_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_waddr] <= open_wdata;
    open_rd_q <= open_mem[open_raddr];
  end

  assign status_o.clr_last = (sweep_q == CELL_AW'(CELLS - 1));
  assign status_o.item_op  = item_op_e'(item_q.operation);
  assign status_o.done     = done_q;
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_full = (cnt_q >= CNT_W'(OPEN_DEPTH));
  assign status_o.scan_end = !scan_issue && !pipe_v_q;
  assign status_o.cur_goal = cur_goal;
  assign status_o.nb_out   = nb_out;
  assign status_o.nb_cell  = cell_rd_q;
  assign status_o.k_last   = (k_q == NB_LAST);
  assign status_o.sq_done  = sq_done;
  assign status_o.out_free = out_free;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  `GASS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(OPEN_DEPTH), "open count above list depth")
  `GASS_NEVER(a_insert_full, (cmd_i.op == DP_INSERT) && status_o.cnt_full, "insert into full list")
  `GASS_ASSERT(a_pipe_src, pipe_v_q |-> ($past(cmd_i.op) == DP_SCAN || $past(cmd_i.op) == DP_SHIFT || $past(cmd_i.op) == DP_RELAX), "scan pipeline valid outside a list pass")

endmodule

FILE: src/grid_astar_search_step.sv
// ----------------------------------------------------------------------------
// Grid A* search step
// One command per input beat: cell write, single node expansion or restart.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) carries one
// command beat; the output channel (out_valid_o, out_stall_i, out_data_o)
// returns exactly one result beat per command. The block works on one
// command at a time and takes the next one as soon as the previous result
// sits in the output register, even if the receiver has not taken it yet.
// After reset a clearing pass frees every map cell; no beat is accepted
// during it, while configuration writes are taken as always. A cell write
// reads the cell and updates it only if it is free or an obstacle, and a
// restart reads every map cell in turn and frees it if closed or open. An
// expansion costs one pass over the N open entries to find the least f,
// one pass over the entries after it to close the gap, then per neighbour
// either a pass over the list to relax an open cell or the heuristic
// square root in the iterative root unit and the insertion. The single
// read port of the open-list memory sets the cost of these passes.
// While the receiver stalls, the result is held and at most one more
// command is accepted, which then waits until the output register frees.
// ----------------------------------------------------------------------------
module grid_astar_search_step import gass_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // The controller holds the sequencing state and issues commands; the search state lives in the datapath.
  cmd_t    cmd;
  status_t status;

  gass_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gass_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
